// ===== rtl/core/mseq_pkg.sv =====
// Shared types and constants for the m-sequence LFSR generator.
package mseq_pkg;

   localparam int ORDER_W = 5;
   localparam int TAPS_W  = 16;
   localparam int POS_W   = 16;
   localparam int CSR_W   = 16;
   localparam int EPOCH_W = 16;

   // register indexes on the csr port
   localparam logic CSR_LFSR_ORDER    = 1'b0;
   localparam logic CSR_FEEDBACK_TAPS = 1'b1;

   localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd16;
   localparam logic [TAPS_W-1:0]  TAPS_RESET  = 16'd45;

   // one result beat
   typedef struct packed {
      logic             seq_bit;
      logic [POS_W-1:0] position;
      logic             last;
      logic             repeat_seen;
      logic             not_maximal;
   } rsp_type;

endpackage

// ===== rtl/core/msequence_lfsr_generator_top.sv =====
// Galois LFSR m-sequence generator with a per-period repeated-state check.
//
// Usage:
//  - req channel: one beat per sequence bit. req_restart = 1 restarts the
//    register at 1, position 0, and clears the visited map and sticky error.
//  - rsp channel: seq_bit, position, last, repeat_seen, not_maximal per beat.
//  - csr port: index 0 = lfsr_order, index 1 = feedback_taps; write only
//    while no beats are in flight.
// An accepted beat first waits in the write stage for its tag read and is then
// pushed into the output queue, from whose head it is offered on rsp.
// Throughput: one beat per cycle while req_stall is low; the visited tag memory
// is read when a beat is accepted and written back from the write stage, and
// back-to-back hits on the same entry are forwarded from the write stage.
// The visited map is a memory of epoch tags (2**MAX_ORDER entries). A tag
// equal to the current period's epoch marks the state as visited. After
// reset, and each time the epoch counter wraps (every 2**16-1 periods), a
// clearing pass writes every tag to zero; req_stall is held high for the pass.
// When the receiver stalls, up to four results wait in an output queue, and
// req_stall rises once the queue and write stage together hold four results.
module msequence_lfsr_generator_top #(
   parameter int MAX_ORDER = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_restart,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_seq_bit,
   output logic [mseq_pkg::POS_W-1:0]  rsp_position,
   output logic                        rsp_last,
   output logic                        rsp_repeat_seen,
   output logic                        rsp_not_maximal,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [mseq_pkg::CSR_W-1:0]  csr_wdata
);

   localparam int DEPTH = 1 << MAX_ORDER;
   localparam int EW    = mseq_pkg::EPOCH_W;

   localparam logic ST_CLEAR = 1'b0;
   localparam logic ST_RUN   = 1'b1;

   localparam logic [EW-1:0] EPOCH_MAX = {EW{1'b1}};

   // write stage: item whose tag read is in flight
   typedef struct packed {
      logic [MAX_ORDER-1:0] addr;
      logic [EW-1:0]        epoch;
      logic [MAX_ORDER-1:0] pos;
      logic                 last;
      logic                 restart;
      logic                 fwd;
   } s1_type;

   // configuration
   logic [mseq_pkg::ORDER_W-1:0] order_ff;
   logic [mseq_pkg::TAPS_W-1:0]  taps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= mseq_pkg::ORDER_RESET;
         taps_ff  <= mseq_pkg::TAPS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            mseq_pkg::CSR_LFSR_ORDER:    order_ff <= csr_wdata[mseq_pkg::ORDER_W-1:0];
            mseq_pkg::CSR_FEEDBACK_TAPS: order_ff <= order_ff;
            default:                     order_ff <= order_ff;
         endcase
         if (csr_index == mseq_pkg::CSR_FEEDBACK_TAPS) begin
            taps_ff <= csr_wdata[mseq_pkg::TAPS_W-1:0];
         end
      end
   end

   // generator state
   logic                 state_ff, state_in;
   logic [MAX_ORDER-1:0] sweep_ff;
   logic [MAX_ORDER-1:0] shift_ff, shift_in;
   logic [MAX_ORDER-1:0] pos_ff, pos_in;
   logic                 done_ff, done_in;
   logic [EW-1:0]        epoch_ff, epoch_in;
   logic                 error_ff, error_in;
   logic                 s1_valid_ff;
   s1_type               s1_ff, s1_in;
   logic [EW-1:0]        rdata_ff;

   // output queue
   mseq_pkg::rsp_type    q_ff [4];
   logic [1:0]           q_head_ff, q_tail_ff;
   logic [2:0]           q_cnt_ff;

   logic                        accept, pop, new_period, wrap_need, q_full;
   logic [mseq_pkg::ORDER_W-1:0] order_eff;
   logic [MAX_ORDER:0]          one_shl;
   logic [MAX_ORDER-1:0]        mask, cur, pos, nxt, taps_ext, top_bit;
   logic [31:0]                 taps32, pos32;
   logic                        high, last;
   logic [3:0]                  occ;
   logic                        rep;
   mseq_pkg::rsp_type           push_rsp;

   // effective order, clamped to 2..MAX_ORDER
   always_comb begin
      if (order_ff < mseq_pkg::ORDER_W'(2)) begin
         order_eff = mseq_pkg::ORDER_W'(2);
      end else if (order_ff > mseq_pkg::ORDER_W'(MAX_ORDER)) begin
         order_eff = mseq_pkg::ORDER_W'(MAX_ORDER);
      end else begin
         order_eff = order_ff;
      end
   end

   // mask wraps to all ones at the full order
   assign one_shl  = {{MAX_ORDER{1'b0}}, 1'b1} << order_eff;
   assign mask     = one_shl[MAX_ORDER-1:0] - {{(MAX_ORDER-1){1'b0}}, 1'b1};
   assign top_bit  = mask & ~(mask >> 1);
   assign taps32   = {{(32-mseq_pkg::TAPS_W){1'b0}}, taps_ff};
   assign taps_ext = taps32[MAX_ORDER-1:0];

   assign new_period = req_restart || done_ff;
   assign cur        = (new_period ? {{(MAX_ORDER-1){1'b0}}, 1'b1} : shift_ff) & mask;
   assign pos        = new_period ? '0 : pos_ff;
   assign last       = pos >= (mask - {{(MAX_ORDER-1){1'b0}}, 1'b1});
   assign high       = |(cur & top_bit);
   assign nxt        = {cur[MAX_ORDER-2:0], 1'b0} ^ (high ? taps_ext : '0);

   // handshake: the epoch wrap waits for the write stage to drain, then clears
   assign occ       = {1'b0, q_cnt_ff} + {3'b0, s1_valid_ff};
   assign q_full    = occ >= 4'd4;
   assign wrap_need = (state_ff == ST_RUN) && req_valid && new_period &&
                      (epoch_ff == EPOCH_MAX);
   assign req_stall = q_full || (state_ff == ST_CLEAR) || wrap_need;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      shift_in = shift_ff;
      pos_in   = pos_ff;
      done_in  = done_ff;
      epoch_in = new_period ? epoch_ff + EW'(1) : epoch_ff;
      s1_in.addr    = cur;
      s1_in.epoch   = epoch_in;
      s1_in.pos     = pos;
      s1_in.last    = last;
      s1_in.restart = req_restart;
      // previous item writes its tag in this same cycle
      s1_in.fwd     = s1_valid_ff && (s1_ff.addr == cur) && (s1_ff.epoch == epoch_in);
      if (accept) begin
         shift_in = nxt & mask;
         pos_in   = pos + {{(MAX_ORDER-1){1'b0}}, 1'b1};
         done_in  = last;
      end else begin
         epoch_in = epoch_ff;
      end
   end

   // clear sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (&sweep_ff) state_in = ST_RUN;
         ST_RUN:   if (wrap_need && !s1_valid_ff) state_in = ST_CLEAR;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         sweep_ff    <= '0;
         shift_ff    <= {{(MAX_ORDER-1){1'b0}}, 1'b1};
         pos_ff      <= '0;
         done_ff     <= 1'b0;
         epoch_ff    <= EW'(1);
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         shift_ff    <= shift_in;
         pos_ff      <= pos_in;
         done_ff     <= done_in;
         s1_valid_ff <= accept;
         if (state_ff == ST_CLEAR) begin
            sweep_ff <= sweep_ff + {{(MAX_ORDER-1){1'b0}}, 1'b1};
            // after a wrap the waiting item opens epoch 1
            if ((&sweep_ff) && (epoch_ff == EPOCH_MAX)) begin
               epoch_ff <= '0;
            end
         end else begin
            epoch_ff <= epoch_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // visited tag memory: one write port, one registered read port
   logic [EW-1:0]        tag_mem_ff [DEPTH];
   logic                 mem_we;
   logic [MAX_ORDER-1:0] mem_waddr;
   logic [EW-1:0]        mem_wdata;

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = s1_valid_ff;
         mem_waddr = s1_ff.addr;
         mem_wdata = s1_ff.epoch;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         rdata_ff <= tag_mem_ff[cur];
      end
   end

   // write stage result and sticky error
   assign rep      = s1_ff.fwd || (rdata_ff == s1_ff.epoch);
   assign error_in = (s1_ff.restart ? 1'b0 : error_ff) || rep;
   assign pos32    = {{(32-MAX_ORDER){1'b0}}, s1_ff.pos};

   always_comb begin
      push_rsp.seq_bit     = s1_ff.addr[0];
      push_rsp.position    = pos32[mseq_pkg::POS_W-1:0];
      push_rsp.last        = s1_ff.last;
      push_rsp.repeat_seen = rep;
      push_rsp.not_maximal = error_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_ff <= 1'b0;
      end else if (s1_valid_ff) begin
         error_ff <= error_in;
      end
   end

   // output queue
   assign rsp_valid = q_cnt_ff != 3'd0;
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_head_ff <= '0;
         q_tail_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         if (s1_valid_ff) q_tail_ff <= q_tail_ff + 2'd1;
         if (pop)         q_head_ff <= q_head_ff + 2'd1;
         q_cnt_ff <= q_cnt_ff + {2'b0, s1_valid_ff} - {2'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         q_ff[q_tail_ff] <= push_rsp;
      end
   end

   assign rsp_seq_bit     = q_ff[q_head_ff].seq_bit;
   assign rsp_position    = q_ff[q_head_ff].position;
   assign rsp_last        = q_ff[q_head_ff].last;
   assign rsp_repeat_seen = q_ff[q_head_ff].repeat_seen;
   assign rsp_not_maximal = q_ff[q_head_ff].not_maximal;

   // checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= 3'd4) else $error("output queue overflow");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == ST_RUN)) else $error("beat accepted during clear");

   a_clear_drained: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_CLEAR) |-> !s1_valid_ff)
      else $error("clear pass overlaps tag write");

   a_repeat_sets_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_repeat_seen) |-> rsp_not_maximal)
      else $error("repeat without sticky error");

endmodule

// ===== tb/msequence_lfsr_generator_top_tb.sv =====
// Self-checking testbench for the Galois LFSR m-sequence generator.
`timescale 1ns / 1ps

module msequence_lfsr_generator_top_tb;

   localparam int MAX_ORDER   = 16;
   localparam int MAP_DEPTH   = 1 << MAX_ORDER;
   // Reset starts a clearing pass over every map tag with req_stall high, so the
   // watchdog must tolerate a quiet stretch well longer than that pass.
   localparam int IDLE_LIMIT  = 4 * MAP_DEPTH;
   localparam int TARGET_BEATS = 650;

   // Tracks the generator state and holds the sequence bits still owed on rsp.
   class mseq_tracker;
      logic [mseq_pkg::ORDER_W-1:0] order_reg;
      logic [mseq_pkg::TAPS_W-1:0]  taps_reg;
      int unsigned        shift_state;
      int unsigned        period_pos;
      bit                 period_over;
      bit                 sticky_err;
      // visited map as epoch tags: a tag equal to cur_epoch means seen
      int unsigned        visit_tag [MAP_DEPTH];
      int unsigned        cur_epoch;
      mseq_pkg::rsp_type  owed_bits [$];
      int                 mismatches;
      int                 bits_checked;
      int                 periods_done;
      int                 repeats_hit;

      function new();
         order_reg  = mseq_pkg::ORDER_RESET;
         taps_reg   = mseq_pkg::TAPS_RESET;
         sticky_err = 1'b0;
         cur_epoch  = 0;
         fresh_period();
      endfunction

      function void fresh_period();
         shift_state = 1;
         period_pos  = 0;
         period_over = 1'b0;
         cur_epoch++;
      endfunction

      function void set_reg(logic idx, logic [mseq_pkg::CSR_W-1:0] value);
         if (idx == mseq_pkg::CSR_LFSR_ORDER)
            order_reg = value[mseq_pkg::ORDER_W-1:0];
         else
            taps_reg = value[mseq_pkg::TAPS_W-1:0];
      endfunction

      function int pending();
         return owed_bits.size();
      endfunction

      // One accepted request beat: step the register and queue the bit it emits.
      function void note_request(bit restart);
         int unsigned       ord, mask, top_bit, cur, nxt;
         mseq_pkg::rsp_type bit_out;
         ord = 32'(order_reg);
         if (ord < 2) ord = 2;
         if (ord > MAX_ORDER) ord = MAX_ORDER;
         mask    = (32'd1 << ord) - 32'd1;
         top_bit = 32'd1 << (ord - 32'd1);
         if (restart) begin
            sticky_err = 1'b0;
            fresh_period();
         end else if (period_over) begin
            fresh_period();   // error stays sticky across periods
         end
         cur = shift_state & mask;
         bit_out.repeat_seen = (visit_tag[cur[MAX_ORDER-1:0]] == cur_epoch);
         visit_tag[cur[MAX_ORDER-1:0]] = cur_epoch;
         if (bit_out.repeat_seen) sticky_err = 1'b1;
         bit_out.seq_bit     = cur[0];
         bit_out.position    = period_pos[mseq_pkg::POS_W-1:0];
         // also true when a shorter order left position past the end
         bit_out.last        = (period_pos >= mask - 32'd1);
         bit_out.not_maximal = sticky_err;
         nxt = cur << 1;
         if ((cur & top_bit) != 0) nxt ^= 32'(taps_reg);
         shift_state = nxt & mask;
         period_pos  = (period_pos + 32'd1) & 32'(MAP_DEPTH - 1);
         period_over = bit_out.last;
         owed_bits.push_back(bit_out);
      endfunction

      function void report(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_bit(mseq_pkg::rsp_type got);
         mseq_pkg::rsp_type want;
         if (owed_bits.size() == 0) begin
            $display("%0t: unexpected rsp beat, expected none got position %0d",
                     $time, got.position);
            mismatches++;
            return;
         end
         want = owed_bits.pop_front();
         report("seq_bit", 32'(want.seq_bit), 32'(got.seq_bit));
         report("position", 32'(want.position), 32'(got.position));
         report("last", 32'(want.last), 32'(got.last));
         report("repeat_seen", 32'(want.repeat_seen), 32'(got.repeat_seen));
         report("not_maximal", 32'(want.not_maximal), 32'(got.not_maximal));
         bits_checked++;
         if (want.last) periods_done++;
         if (want.repeat_seen) repeats_hit++;
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_restart;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic                         rsp_seq_bit;
   logic [mseq_pkg::POS_W-1:0]   rsp_position;
   logic                         rsp_last;
   logic                         rsp_repeat_seen;
   logic                         rsp_not_maximal;
   logic                         csr_we;
   logic                         csr_index;
   logic [mseq_pkg::CSR_W-1:0]   csr_wdata;

   mseq_tracker tracker;
   bit          quiet;        // no idling on either side while set
   int          beats_sent;
   int          reg_writes;

   msequence_lfsr_generator_top #(.MAX_ORDER(MAX_ORDER)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_seq_bit     (rsp_seq_bit),
      .rsp_position    (rsp_position),
      .rsp_last        (rsp_last),
      .rsp_repeat_seen (rsp_repeat_seen),
      .rsp_not_maximal (rsp_not_maximal),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Push one request beat. Valid stays up when no gap is drawn, so
   // back-to-back beats never drop valid within one edge.
   task automatic send_beat(input bit restart);
      int gap;
      gap = quiet ? 0 : int'($urandom_range(0, 3));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      tracker.note_request(restart);
      beats_sent++;
   endtask

   // Stop sending and wait for every owed bit, then keep clocking with valid low
   // so the block is truly idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // csr write: one cycle with we high, then one with it low
   task automatic write_reg(input logic idx, input logic [mseq_pkg::CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      tracker.set_reg(idx, value);
      reg_writes++;
   endtask

   // Response side: accept beats, then draw a random stall (none while quiet).
   initial begin : rsp_side
      mseq_pkg::rsp_type got;
      int                hold;
      hold = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.seq_bit     = rsp_seq_bit;
            got.position    = rsp_position;
            got.last        = rsp_last;
            got.repeat_seen = rsp_repeat_seen;
            got.not_maximal = rsp_not_maximal;
            tracker.check_bit(got);
            hold = quiet ? 0 : int'($urandom_range(0, 3));
         end else if (hold > 0) begin
            hold--;
         end
         rsp_stall <= (hold > 0);
      end
   end

   // Watchdog: ends the run if no beat moves on either channel for too long.
   initial begin : watchdog
      int idle_run;
      idle_run = 0;
      while (idle_run < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_run = 0;
         else
            idle_run++;
      end
      $display("%0t: timeout, no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      int                         len;
      int                         sel;
      int unsigned                eff;
      logic [mseq_pkg::CSR_W-1:0] value;
      tracker     = new();
      quiet       = 1'b0;
      beats_sent  = 0;
      reg_writes  = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_restart <= 1'b0;
      csr_we      <= 1'b0;
      csr_index   <= mseq_pkg::CSR_LFSR_ORDER;
      csr_wdata   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // Power-on settings (order 16, taps 45), then a restart mid-period.
      send_beat(1'b0);
      send_beat(1'b0);
      send_beat(1'b0);
      send_beat(1'b1);
      send_beat(1'b0);
      settle();

      // Stuck register: order 3 with taps that send state 4 to zero, so the
      // zero state repeats, the error latches, and survives the period end.
      write_reg(mseq_pkg::CSR_LFSR_ORDER, 16'd3);
      write_reg(mseq_pkg::CSR_FEEDBACK_TAPS, 16'hFFF8);
      send_beat(1'b1);
      repeat (7) send_beat(1'b0);
      send_beat(1'b1);          // restart clears the sticky error
      send_beat(1'b0);
      settle();

      // Order above the maximum clamps to 16; all-ones taps.
      write_reg(mseq_pkg::CSR_LFSR_ORDER, 16'd31);
      write_reg(mseq_pkg::CSR_FEEDBACK_TAPS, 16'hFFFF);
      repeat (4) send_beat(1'b0);
      settle();

      // Order shrinks mid-period (1 with junk upper bits acts as 2): position
      // is already past the short period, so last comes at once.
      write_reg(mseq_pkg::CSR_LFSR_ORDER, 16'hFFE1);
      write_reg(mseq_pkg::CSR_FEEDBACK_TAPS, 16'h0001);
      repeat (3) send_beat(1'b0);

      // --- random part: phases of settings, each drained before the next ---
      while (beats_sent < TARGET_BEATS) begin
         settle();
         quiet = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 4) != 0) begin
            sel = int'($urandom_range(0, 9));
            if (sel < 6)      value = mseq_pkg::CSR_W'($urandom_range(2, 7));
            else if (sel < 7) value = mseq_pkg::CSR_W'($urandom_range(8, 16));
            else if (sel < 8) value = mseq_pkg::CSR_W'($urandom_range(0, 1));
            else if (sel < 9) value = mseq_pkg::CSR_W'($urandom_range(17, 31));
            else              value = 16'd16;
            if ($urandom_range(0, 3) == 0)
               value[mseq_pkg::CSR_W-1:mseq_pkg::ORDER_W] =
                  (mseq_pkg::CSR_W - mseq_pkg::ORDER_W)'($urandom);
            write_reg(mseq_pkg::CSR_LFSR_ORDER, value);
         end
         if ($urandom_range(0, 4) != 0) begin
            eff = 32'(tracker.order_reg);
            if (eff < 2) eff = 2;
            if (eff > MAX_ORDER) eff = MAX_ORDER;
            sel = int'($urandom_range(0, 9));
            if (sel < 4) begin
               // primitive for orders 2..7 and 16, so full periods run to the end
               case (eff) inside
                  5:             value = 16'h0005;
                  16:            value = 16'h002D;
                  2, 3, 4, 6, 7: value = 16'h0003;
                  default:       value = mseq_pkg::CSR_W'($urandom_range(1, 16'hFFFF));
               endcase
            end else if (sel < 8) begin
               value = mseq_pkg::CSR_W'($urandom_range(1, 16'hFFFF));
            end else if (sel < 9) begin
               value = 16'h0001;
            end else begin
               value = 16'hFFFF;
            end
            write_reg(mseq_pkg::CSR_FEEDBACK_TAPS, value);
         end
         len = int'($urandom_range(8, 60));
         for (int i = 0; i < len; i++)
            send_beat(i == 0 ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 24) == 0));
      end
      settle();

      $display("covered %0d request beats and %0d register writes, orders 0..31",
               beats_sent, reg_writes);
      $display("checked %0d bits: %0d periods ended, %0d repeated states",
               tracker.bits_checked, tracker.periods_done, tracker.repeats_hit);
      if (tracker.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mseq_pkg.sv
rtl/core/msequence_lfsr_generator_top.sv
tb/msequence_lfsr_generator_top_tb.sv
